@@ rtl/crt_sra_pkg.sv @@
// Shared constants and widths for the CRT scanline row alpha unit.
package crt_sra_pkg;

   localparam int SOURCE_LINES = 224;
   localparam int ROW_BITS     = 12;

   localparam int STRENGTH_W = 7;
   localparam int HEIGHT_W   = 12;
   localparam int ALPHA_W    = 8;
   localparam int FRAC_W     = 16;

   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = 12;
   localparam logic [CSR_INDEX_W-1:0] CSR_STRENGTH = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_HEIGHT   = 1'd1;

   localparam logic [HEIGHT_W-1:0]   HEIGHT_RESET = 12'd224;
   localparam logic [STRENGTH_W-1:0] STRENGTH_MAX = 7'd100;

   // (2*row+1)*SOURCE_LINES divided by 2*height, fraction kept to FRAC_W bits
   localparam int SRC_W      = $clog2(SOURCE_LINES + 1);
   localparam int NUM_W      = ROW_BITS + 1 + SRC_W;
   localparam int DEN_W      = HEIGHT_W + 1;
   localparam int DIVIDEND_W = NUM_W + FRAC_W;
   localparam int DIV_STEPS  = 4;
   localparam int DIV_STAGES = (DIVIDEND_W + DIV_STEPS - 1) / DIV_STEPS;
   localparam int PAD_W      = DIV_STAGES * DIV_STEPS;

   // Q2.16 weight constants
   localparam int Q_ONE_45 = 95027;
   localparam int Q_TWO_05 = 134349;

   localparam int ALPHA_DEN   = Q_ONE_45 * 100;
   localparam int ALPHA_BIAS  = Q_ONE_45 * 50;
   localparam int ALPHA_MAX   = 255;
   localparam int N_W         = 32;
   localparam int RECIP_W     = 32;
   localparam int RECIP_SHIFT = 55;
   localparam logic [RECIP_W-1:0] RECIP =
      RECIP_W'((64'd1 << RECIP_SHIFT) / ALPHA_DEN);

   localparam int SHAPE_STAGES = 7;
   localparam int LATENCY      = 1 + DIV_STAGES + SHAPE_STAGES;

endpackage

@@ rtl/crt_scanline_row_alpha_unit.sv @@
// Top level of the CRT scanline row alpha unit.
//
// Give a row index on req_row_index with start high; the item is taken at
// that clock edge whenever busy is low. busy is never raised, so a new row
// may be offered in every cycle and rows stream at one item per clock.
// Each result appears on rsp_alpha for one cycle with rsp_valid high;
// results leave in the order the rows came in. Each row passes through the
// input register, the ten stage divider that forms the phase (four quotient
// bits a stage) and seven stages of polynomial and alpha scaling.
// The receiver cannot stall: results are simply presented and dropped after
// their cycle.
// csr_write_enable with csr_index 0 writes the strength in percent, index 1
// the output height in rows; writes take effect at once and belong in idle
// periods. Reset clears all items in flight and sets strength to zero and
// height to 224.
module crt_scanline_row_alpha_unit (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   output logic                                  busy,
   input  logic [crt_sra_pkg::ROW_BITS-1:0]      req_row_index,
   output logic                                  rsp_valid,
   output logic [crt_sra_pkg::ALPHA_W-1:0]       rsp_alpha,
   input  logic                                  csr_write_enable,
   input  logic [crt_sra_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [crt_sra_pkg::CSR_DATA_W-1:0]    csr_write_data
);

   logic [crt_sra_pkg::STRENGTH_W-1:0] strength_ff;
   logic [crt_sra_pkg::HEIGHT_W-1:0]   height_ff;
   logic [crt_sra_pkg::STRENGTH_W-1:0] strength_eff;
   logic [crt_sra_pkg::HEIGHT_W-1:0]   height_eff;
   logic [crt_sra_pkg::DEN_W-1:0]      den;

   logic                               accept;
   logic                               req_vld_ff;
   logic [crt_sra_pkg::NUM_W-1:0]      num_in, num_ff;

   logic                               div_valid;
   logic [crt_sra_pkg::FRAC_W-1:0]     div_phase;

   assign busy   = 1'b0;
   assign accept = start && !busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         strength_ff <= '0;
         height_ff   <= crt_sra_pkg::HEIGHT_RESET;
      end else if (csr_write_enable) begin
         case (csr_index)
            crt_sra_pkg::CSR_STRENGTH:
               strength_ff <= csr_write_data[crt_sra_pkg::STRENGTH_W-1:0];
            crt_sra_pkg::CSR_HEIGHT:
               height_ff <= csr_write_data[crt_sra_pkg::HEIGHT_W-1:0];
            default: begin
            end
         endcase
      end
   end

   assign strength_eff = (strength_ff > crt_sra_pkg::STRENGTH_MAX) ? crt_sra_pkg::STRENGTH_MAX
                                                                   : strength_ff;
   assign height_eff   = (height_ff == '0) ? crt_sra_pkg::HEIGHT_W'(1) : height_ff;
   assign den          = {height_eff, 1'b0};

   // numerator (2*row+1)*source lines
   assign num_in = crt_sra_pkg::NUM_W'({req_row_index, 1'b1})
                   * crt_sra_pkg::NUM_W'(crt_sra_pkg::SOURCE_LINES);

   always_ff @(posedge clock) begin
      if (reset) begin
         req_vld_ff <= 1'b0;
      end else begin
         req_vld_ff <= accept;
      end
      num_ff <= num_in;
   end

   crt_sra_divider u_divider (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_vld_ff),
      .in_num    (num_ff),
      .den       (den),
      .out_valid (div_valid),
      .out_phase (div_phase)
   );

   crt_sra_shaper u_shaper (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (div_valid),
      .in_phase  (div_phase),
      .strength  (strength_eff),
      .out_valid (rsp_valid),
      .out_alpha (rsp_alpha)
   );

   a_item_emerges: assert property (@(posedge clock) disable iff (reset)
      accept |-> ##(crt_sra_pkg::LATENCY) rsp_valid)
      else $error("accepted item did not produce a result on time");

   a_no_spurious_result: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(accept, crt_sra_pkg::LATENCY))
      else $error("result without a matching accepted item");

endmodule

@@ rtl/crt_sra_divider.sv @@
// Pipelined restoring divider giving the fractional phase of a row in its source line.
module crt_sra_divider (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             in_valid,
   input  logic [crt_sra_pkg::NUM_W-1:0]    in_num,
   input  logic [crt_sra_pkg::DEN_W-1:0]    den,
   output logic                             out_valid,
   output logic [crt_sra_pkg::FRAC_W-1:0]   out_phase
);

   typedef struct packed {
      logic [crt_sra_pkg::DEN_W-1:0]  rem;
      logic [crt_sra_pkg::PAD_W-1:0]  dvd;
      logic [crt_sra_pkg::FRAC_W-1:0] quo;
   } div_stage_type;

   function automatic div_stage_type div_steps(input div_stage_type s,
                                               input logic [crt_sra_pkg::DEN_W-1:0] d);
      div_stage_type                 r;
      logic [crt_sra_pkg::DEN_W:0]   trial;
      r = s;
      for (int k = 0; k < crt_sra_pkg::DIV_STEPS; k++) begin
         trial = {r.rem, r.dvd[crt_sra_pkg::PAD_W-1]};
         r.dvd = {r.dvd[crt_sra_pkg::PAD_W-2:0], 1'b0};
         if (trial >= {1'b0, d}) begin
            r.rem = crt_sra_pkg::DEN_W'(trial - {1'b0, d});
            r.quo = {r.quo[crt_sra_pkg::FRAC_W-2:0], 1'b1};
         end else begin
            r.rem = trial[crt_sra_pkg::DEN_W-1:0];
            r.quo = {r.quo[crt_sra_pkg::FRAC_W-2:0], 1'b0};
         end
      end
      return r;
   endfunction

   div_stage_type                           first_stage;
   div_stage_type                           stage_in [crt_sra_pkg::DIV_STAGES];
   div_stage_type                           stage_ff [crt_sra_pkg::DIV_STAGES];
   logic [crt_sra_pkg::DIV_STAGES-1:0]      vld_ff;

   always_comb begin
      first_stage.rem = '0;
      first_stage.dvd = crt_sra_pkg::PAD_W'({in_num, crt_sra_pkg::FRAC_W'(0)});
      first_stage.quo = '0;
      stage_in[0] = div_steps(first_stage, den);
      for (int g = 1; g < crt_sra_pkg::DIV_STAGES; g++) begin
         stage_in[g] = div_steps(stage_ff[g-1], den);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= {vld_ff[crt_sra_pkg::DIV_STAGES-2:0], in_valid};
      end
      for (int g = 0; g < crt_sra_pkg::DIV_STAGES; g++) begin
         stage_ff[g] <= stage_in[g];
      end
   end

   assign out_valid = vld_ff[crt_sra_pkg::DIV_STAGES-1];
   assign out_phase = stage_ff[crt_sra_pkg::DIV_STAGES-1].quo;

endmodule

@@ rtl/crt_sra_shaper.sv @@
// Scanline weight polynomial and alpha scaling pipeline.
module crt_sra_shaper (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                in_valid,
   input  logic [crt_sra_pkg::FRAC_W-1:0]      in_phase,
   input  logic [crt_sra_pkg::STRENGTH_W-1:0]  strength,
   output logic                                out_valid,
   output logic [crt_sra_pkg::ALPHA_W-1:0]     out_alpha
);

   localparam int D2_W  = 15;
   localparam int D4_W  = 13;
   localparam int T_W   = 15;
   localparam int P_W   = 17;
   localparam int W_W   = 21;
   localparam int X_W   = 17;
   localparam int XS_W  = 24;
   localparam int PR_W  = crt_sra_pkg::N_W + crt_sra_pkg::RECIP_W;
   localparam int Q0_W  = PR_W - crt_sra_pkg::RECIP_SHIFT;

   logic [crt_sra_pkg::SHAPE_STAGES-1:0] vld_ff;

   // stage 1: |d| squared
   logic [15:0]              ad_c;
   logic [31:0]              sq_c;
   logic [D2_W-1:0]          d2_p1_in, d2_p1_ff;
   // stage 2: d^4
   logic [2*D2_W-1:0]        sq2_c;
   logic [D2_W-1:0]          d2_p2_ff;
   logic [D4_W-1:0]          d4_p2_in, d4_p2_ff;
   // stage 3: 2.05*d^4
   logic [30:0]              pt_c;
   logic [D2_W-1:0]          d2_p3_ff;
   logic [T_W-1:0]           t_p3_in, t_p3_ff;
   // stage 4: weight and darkening
   logic signed [P_W-1:0]    poly_c;
   logic signed [W_W-1:0]    poly6_c, wt_c;
   logic [X_W-1:0]           x_p4_in, x_p4_ff;
   // stage 5: scaled numerator
   logic [XS_W-1:0]          xs_c;
   logic [crt_sra_pkg::N_W-1:0] n_p5_in, n_p5_ff, n_p6_ff;
   // stage 6: reciprocal estimate
   logic [PR_W-1:0]          prod_c;
   logic [Q0_W-1:0]          q0_p6_in, q0_p6_ff;
   // stage 7: correction
   logic [crt_sra_pkg::N_W-1:0] qd_c, r_c;
   logic [Q0_W-1:0]          q_c;
   logic [crt_sra_pkg::ALPHA_W-1:0] alpha_in, alpha_ff;

   always_comb begin
      ad_c     = in_phase[crt_sra_pkg::FRAC_W-1] ? {1'b0, in_phase[crt_sra_pkg::FRAC_W-2:0]}
                                                : 16'h8000 - in_phase;
      sq_c     = 32'(ad_c) * 32'(ad_c);
      d2_p1_in = sq_c[30:16];

      sq2_c    = (2*D2_W)'(d2_p1_ff) * (2*D2_W)'(d2_p1_ff);
      d4_p2_in = sq2_c[28:16];

      pt_c     = 31'(crt_sra_pkg::Q_TWO_05) * 31'(d4_p2_ff);
      t_p3_in  = pt_c[30:16];

      poly_c   = $signed({2'b00, d2_p3_ff}) - $signed({2'b00, t_p3_ff});
      poly6_c  = W_W'(poly_c) * W_W'(6);
      wt_c     = W_W'(crt_sra_pkg::Q_ONE_45) - poly6_c;
      if (wt_c < 0) begin
         x_p4_in = X_W'(crt_sra_pkg::Q_ONE_45);
      end else if (wt_c > W_W'(crt_sra_pkg::Q_ONE_45)) begin
         x_p4_in = '0;
      end else begin
         x_p4_in = X_W'(W_W'(crt_sra_pkg::Q_ONE_45) - wt_c);
      end

      xs_c     = XS_W'(x_p4_ff) * XS_W'(strength);
      n_p5_in  = crt_sra_pkg::N_W'({xs_c, 8'b0}) - crt_sra_pkg::N_W'(xs_c)
                 + crt_sra_pkg::N_W'(crt_sra_pkg::ALPHA_BIAS);

      prod_c   = PR_W'(n_p5_ff) * PR_W'(crt_sra_pkg::RECIP);
      q0_p6_in = prod_c[PR_W-1:crt_sra_pkg::RECIP_SHIFT];

      qd_c     = crt_sra_pkg::N_W'(q0_p6_ff) * crt_sra_pkg::N_W'(crt_sra_pkg::ALPHA_DEN);
      r_c      = n_p6_ff - qd_c;
      q_c      = (r_c >= crt_sra_pkg::N_W'(crt_sra_pkg::ALPHA_DEN)) ? q0_p6_ff + 1'b1
                                                                  : q0_p6_ff;
      alpha_in = (q_c > Q0_W'(crt_sra_pkg::ALPHA_MAX)) ? crt_sra_pkg::ALPHA_W'(crt_sra_pkg::ALPHA_MAX)
                                                     : q_c[crt_sra_pkg::ALPHA_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= {vld_ff[crt_sra_pkg::SHAPE_STAGES-2:0], in_valid};
      end
      d2_p1_ff <= d2_p1_in;
      d2_p2_ff <= d2_p1_ff;
      d4_p2_ff <= d4_p2_in;
      d2_p3_ff <= d2_p2_ff;
      t_p3_ff  <= t_p3_in;
      x_p4_ff  <= x_p4_in;
      n_p5_ff  <= n_p5_in;
      n_p6_ff  <= n_p5_ff;
      q0_p6_ff <= q0_p6_in;
      alpha_ff <= alpha_in;
   end

   assign out_valid = vld_ff[crt_sra_pkg::SHAPE_STAGES-1];
   assign out_alpha = alpha_ff;

endmodule

@@ test/crt_scanline_row_alpha_unit_tb.sv @@
// Self-checking testbench for the CRT scanline row alpha unit.
module crt_scanline_row_alpha_unit_tb;

   localparam int CYCLE_LIMIT = 200000;
   localparam int RANDOM_ROWS = 1750;
   localparam int ROWS_PER_SETTING = 125;

   typedef enum logic {STEP_CSR, STEP_ROW} step_kind_type;

   typedef struct packed {
      step_kind_type                       kind;
      logic [crt_sra_pkg::CSR_INDEX_W-1:0] index;
      logic [crt_sra_pkg::CSR_DATA_W-1:0]  value;
      logic                                typed;
      logic [crt_sra_pkg::ALPHA_W-1:0]     alpha;
   } step_type;

   logic                                clock = 1'b0;
   logic                                reset = 1'b1;
   logic                                start = 1'b0;
   logic                                busy;
   logic [crt_sra_pkg::ROW_BITS-1:0]    req_row_index = '0;
   logic                                rsp_valid;
   logic [crt_sra_pkg::ALPHA_W-1:0]     rsp_alpha;
   logic                                csr_write_enable = 1'b0;
   logic [crt_sra_pkg::CSR_INDEX_W-1:0] csr_index = crt_sra_pkg::CSR_STRENGTH;
   logic [crt_sra_pkg::CSR_DATA_W-1:0]  csr_write_data = '0;

   logic [crt_sra_pkg::STRENGTH_W-1:0]  strength_reg = '0;
   logic [crt_sra_pkg::HEIGHT_W-1:0]    height_reg = crt_sra_pkg::HEIGHT_RESET;
   logic [crt_sra_pkg::ALPHA_W-1:0]     alpha_queue[$];
   logic                                typed_valid = 1'b0;
   logic [crt_sra_pkg::ALPHA_W-1:0]     typed_alpha = '0;
   step_type                            steps[$];

   int accept_count = 0;
   int result_count = 0;
   int mismatch_count = 0;
   int setting_count = 0;
   int cycle_count = 0;

   crt_scanline_row_alpha_unit dut (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_row_index   (req_row_index),
      .rsp_valid       (rsp_valid),
      .rsp_alpha       (rsp_alpha),
      .csr_write_enable(csr_write_enable),
      .csr_index       (csr_index),
      .csr_write_data  (csr_write_data)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   function automatic logic [crt_sra_pkg::ALPHA_W-1:0] scanline_alpha(
         input logic [crt_sra_pkg::ROW_BITS-1:0]   row,
         input logic [crt_sra_pkg::STRENGTH_W-1:0] strength,
         input logic [crt_sra_pkg::HEIGHT_W-1:0]   height);
      longint unsigned r, s, h, den, num, phase, a;
      longint d, d2, d4, poly, w;
      r = row;
      s = (strength > crt_sra_pkg::STRENGTH_MAX) ? longint'(crt_sra_pkg::STRENGTH_MAX)
                                                 : longint'(strength);
      h = (height == 0) ? 1 : height;
      den = 2 * h;
      num = (2 * r + 1) * crt_sra_pkg::SOURCE_LINES;
      phase = ((num % den) << crt_sra_pkg::FRAC_W) / den;
      d = longint'(phase) - 32768;
      d2 = (d * d) >> crt_sra_pkg::FRAC_W;
      d4 = (d2 * d2) >> crt_sra_pkg::FRAC_W;
      poly = d2 - ((longint'(crt_sra_pkg::Q_TWO_05) * d4) >> crt_sra_pkg::FRAC_W);
      w = longint'(crt_sra_pkg::Q_ONE_45) - 6 * poly;
      if (w < 0) w = 0;
      if (w > crt_sra_pkg::Q_ONE_45) w = crt_sra_pkg::Q_ONE_45;
      a = (longint'(crt_sra_pkg::Q_ONE_45 - w) * s * 255
           + longint'(crt_sra_pkg::Q_ONE_45) * 50)
          / (longint'(crt_sra_pkg::Q_ONE_45) * 100);
      if (a > crt_sra_pkg::ALPHA_MAX) a = crt_sra_pkg::ALPHA_MAX;
      return a[crt_sra_pkg::ALPHA_W-1:0];
   endfunction

   // results, then accepted items, then register writes, all at the rising edge
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d alphas outstanding",
                  cycle_count, alpha_queue.size());
         $display("end of test: mismatches");
         $finish;
      end else if (reset) begin
         strength_reg <= '0;
         height_reg <= crt_sra_pkg::HEIGHT_RESET;
      end else begin
         if (rsp_valid) begin
            result_count <= result_count + 1;
            if (alpha_queue.size() == 0) begin
               if (mismatch_count < 10)
                  $display("unexpected alpha %0d", rsp_alpha);
               mismatch_count <= mismatch_count + 1;
            end else begin
               if (rsp_alpha !== alpha_queue[0]) begin
                  if (mismatch_count < 10)
                     $display("alpha mismatch: expected %0d, got %0d",
                              alpha_queue[0], rsp_alpha);
                  mismatch_count <= mismatch_count + 1;
               end
               void'(alpha_queue.pop_front());
            end
         end
         if (start && !busy) begin
            accept_count <= accept_count + 1;
            alpha_queue.push_back(typed_valid ? typed_alpha
                                  : scanline_alpha(req_row_index, strength_reg, height_reg));
         end
         if (csr_write_enable) begin
            if (csr_index == crt_sra_pkg::CSR_STRENGTH)
               strength_reg <= csr_write_data[crt_sra_pkg::STRENGTH_W-1:0];
            else if (csr_index == crt_sra_pkg::CSR_HEIGHT)
               height_reg <= csr_write_data[crt_sra_pkg::HEIGHT_W-1:0];
         end
      end
   end

   // called and returns at a falling edge; start stays high afterwards
   task automatic drive_row(input logic [crt_sra_pkg::ROW_BITS-1:0] row);
      int taken;
      taken = accept_count;
      start = 1'b1;
      req_row_index = row;
      do @(negedge clock); while (accept_count == taken);
   endtask

   task automatic idle_cycles(input int n);
      start = 1'b0;
      repeat (n) begin
         req_row_index = crt_sra_pkg::ROW_BITS'($urandom);
         @(negedge clock);
      end
   endtask

   task automatic wait_drained();
      start = 1'b0;
      while (alpha_queue.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_csr(input logic [crt_sra_pkg::CSR_INDEX_W-1:0] index,
                            input logic [crt_sra_pkg::CSR_DATA_W-1:0] value);
      csr_write_enable = 1'b1;
      csr_index = index;
      csr_write_data = value;
      @(negedge clock);
      csr_write_enable = 1'b0;
      csr_write_data = crt_sra_pkg::CSR_DATA_W'($urandom);
      setting_count++;
   endtask

   task automatic add_csr(input logic [crt_sra_pkg::CSR_INDEX_W-1:0] index,
                          input logic [crt_sra_pkg::CSR_DATA_W-1:0] value);
      steps.push_back('{STEP_CSR, index, value, 1'b0, '0});
   endtask

   task automatic add_row(input logic [crt_sra_pkg::ROW_BITS-1:0] row, input logic typed,
                          input logic [crt_sra_pkg::ALPHA_W-1:0] alpha);
      steps.push_back('{STEP_ROW, crt_sra_pkg::CSR_STRENGTH,
                        crt_sra_pkg::CSR_DATA_W'(row), typed, alpha});
   endtask

   initial begin
      logic [crt_sra_pkg::STRENGTH_W-1:0] strength;
      logic [crt_sra_pkg::HEIGHT_W-1:0]   height;
      logic [crt_sra_pkg::ROW_BITS-1:0]   row;
      int sent, burst, phase_rows, gappy;

      // strength zero after reset
      add_row(12'd0, 1'b1, 8'd0);
      add_row(12'd4095, 1'b1, 8'd0);
      // height 224 puts every row at mid phase, so no darkening
      add_csr(crt_sra_pkg::CSR_STRENGTH, 12'd100);
      add_row(12'd0, 1'b1, 8'd0);
      add_row(12'd4095, 1'b1, 8'd0);
      add_csr(crt_sra_pkg::CSR_HEIGHT, 12'd4095);
      add_row(12'd0, 1'b0, '0);
      add_row(12'd2047, 1'b0, '0);
      add_row(12'd4095, 1'b0, '0);
      // zero height taken as one
      add_csr(crt_sra_pkg::CSR_HEIGHT, 12'd0);
      add_row(12'd0, 1'b0, '0);
      add_row(12'd4095, 1'b0, '0);
      // strength above a hundred
      add_csr(crt_sra_pkg::CSR_STRENGTH, 12'd127);
      add_row(12'd1, 1'b0, '0);
      add_row(12'd3000, 1'b0, '0);
      add_csr(crt_sra_pkg::CSR_HEIGHT, 12'd1);
      add_row(12'd5, 1'b0, '0);
      add_csr(crt_sra_pkg::CSR_STRENGTH, 12'd101);
      add_row(12'd7, 1'b0, '0);
      add_csr(crt_sra_pkg::CSR_HEIGHT, 12'd112);
      add_row(12'd0, 1'b0, '0);
      add_row(12'd1, 1'b0, '0);
      // upper data bits dropped: strength becomes zero
      add_csr(crt_sra_pkg::CSR_STRENGTH, 12'hF80);
      add_row(12'd100, 1'b1, 8'd0);
      // rows past the height repeat the pattern
      add_csr(crt_sra_pkg::CSR_HEIGHT, 12'd300);
      add_csr(crt_sra_pkg::CSR_STRENGTH, 12'd50);
      add_row(12'd299, 1'b0, '0);
      add_row(12'd300, 1'b0, '0);
      add_row(12'd600, 1'b0, '0);
      add_csr(crt_sra_pkg::CSR_HEIGHT, 12'd224);
      add_csr(crt_sra_pkg::CSR_STRENGTH, 12'd100);
      add_row(12'd223, 1'b1, 8'd0);

      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      @(negedge clock);

      foreach (steps[i]) begin
         if (steps[i].kind == STEP_CSR) begin
            wait_drained();
            write_csr(steps[i].index, steps[i].value);
         end else begin
            typed_valid = steps[i].typed;
            typed_alpha = steps[i].alpha;
            drive_row(steps[i].value[crt_sra_pkg::ROW_BITS-1:0]);
         end
      end
      start = 1'b0;
      typed_valid = 1'b0;

      sent = 0;
      while (sent < RANDOM_ROWS) begin
         wait_drained();
         case ($urandom_range(0, 5))
            0: strength = '0;
            1: strength = crt_sra_pkg::STRENGTH_MAX;
            2: strength = crt_sra_pkg::STRENGTH_W'($urandom_range(101, 127));
            default: strength = crt_sra_pkg::STRENGTH_W'($urandom_range(1, 99));
         endcase
         case ($urandom_range(0, 6))
            0: height = '0;
            1: height = 12'd1;
            2: height = 12'd4095;
            3: height = crt_sra_pkg::HEIGHT_RESET;
            4: height = crt_sra_pkg::HEIGHT_W'($urandom_range(2, 31));
            default: height = crt_sra_pkg::HEIGHT_W'($urandom_range(1, 4095));
         endcase
         if ($urandom_range(0, 3) != 0)
            write_csr(crt_sra_pkg::CSR_STRENGTH,
                      (crt_sra_pkg::CSR_DATA_W'($urandom) & 12'hF80)
                      | crt_sra_pkg::CSR_DATA_W'(strength));
         if ($urandom_range(0, 3) != 0)
            write_csr(crt_sra_pkg::CSR_HEIGHT, height);
         idle_cycles($urandom_range(0, 3));
         gappy = ($urandom_range(0, 3) != 0);
         phase_rows = 0;
         while (phase_rows < ROWS_PER_SETTING && sent < RANDOM_ROWS) begin
            burst = gappy ? $urandom_range(1, 24) : ROWS_PER_SETTING;
            while (burst > 0 && phase_rows < ROWS_PER_SETTING && sent < RANDOM_ROWS) begin
               if ($urandom_range(0, 9) < 6 || height_reg == 0)
                  row = crt_sra_pkg::ROW_BITS'($urandom);
               else
                  row = crt_sra_pkg::ROW_BITS'($urandom_range(0, height_reg - 1));
               drive_row(row);
               burst--;
               phase_rows++;
               sent++;
            end
            if (gappy)
               idle_cycles($urandom_range(1, 8));
         end
      end

      start = 1'b0;
      while (alpha_queue.size() != 0) @(negedge clock);
      repeat (crt_sra_pkg::LATENCY + 4) @(negedge clock);
      if (alpha_queue.size() != 0)
         mismatch_count++;

      $display("%0d rows driven over %0d register writes, %0d alphas compared",
               accept_count, setting_count, result_count);
      $display("strengths 0 to 127 and heights 0 to 4095 with bursty and back to back rows");
      if (mismatch_count == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

endmodule

@@ files.f @@
rtl/crt_sra_pkg.sv
rtl/crt_sra_divider.sv
rtl/crt_sra_shaper.sv
rtl/crt_scanline_row_alpha_unit.sv
test/crt_scanline_row_alpha_unit_tb.sv
